/* rtl/ssq_pkg.sv */
// Shared types, constants, microcode and helper functions for the sine-squared series block.
package ssq_pkg;

    // Field and datapath widths.
    localparam int ANGLE_W    = 31;   // signed Q3.28 angle
    localparam int AX_W       = 31;   // magnitude of the angle, up to 2^30
    localparam int TOL_W      = 32;   // unsigned Q0.32 tolerance
    localparam int SUM_W      = 40;   // signed Q8.32 sum
    localparam int CNT_OUT_W  = 6;    // term count on the port
    localparam int MAG_W      = 40;   // term magnitude, Q8.32, saturating
    localparam int X2_W       = 37;   // x squared in Q5.32
    localparam int Q4_W       = 39;   // 4 * x squared
    localparam int ACC_W      = 79;   // full product of magnitude and 4 * x squared
    localparam int MLO_W      = 20;   // low slice of the multiplier operand
    localparam int P_W        = 47;   // product scaled down by 2^32
    localparam int DVD_W      = 48;   // rounded dividend
    localparam int D_W        = 14;   // divisor (2n+1)(2n+2)
    localparam int DIV_DIGIT  = 8;    // quotient bits per divider step
    localparam int DIV_STEPS  = DVD_W / DIV_DIGIT;
    localparam int K_W        = $clog2(DIV_STEPS);
    localparam int NIDX_W     = 6;    // term index width seen by the divisor function

    localparam int MAX_TERMS_DEF = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd4295;

    // Microcode fields.
    localparam int OP_W  = 4;
    localparam int CND_W = 3;
    localparam int PC_W  = 4;

    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_SQUARE   = 4'd2;
    localparam logic [OP_W-1:0] OP_INIT     = 4'd3;
    localparam logic [OP_W-1:0] OP_ACCUM    = 4'd4;
    localparam logic [OP_W-1:0] OP_TEST     = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_LO   = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_HI   = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_DONE = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd11;

    localparam logic [CND_W-1:0] C_NEVER    = 3'd0;
    localparam logic [CND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [CND_W-1:0] C_NO_REQ   = 3'd2;
    localparam logic [CND_W-1:0] C_STOP     = 3'd3;
    localparam logic [CND_W-1:0] C_DIV_MORE = 3'd4;
    localparam logic [CND_W-1:0] C_OUT_BUSY = 3'd5;

    // Program steps.
    localparam logic [PC_W-1:0] S_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] S_SQUARE   = 4'd1;
    localparam logic [PC_W-1:0] S_INIT     = 4'd2;
    localparam logic [PC_W-1:0] S_ACCUM    = 4'd3;
    localparam logic [PC_W-1:0] S_TEST     = 4'd4;
    localparam logic [PC_W-1:0] S_MUL_LO   = 4'd5;
    localparam logic [PC_W-1:0] S_MUL_HI   = 4'd6;
    localparam logic [PC_W-1:0] S_DIV_INIT = 4'd7;
    localparam logic [PC_W-1:0] S_DIV_STEP = 4'd8;
    localparam logic [PC_W-1:0] S_DIV_DONE = 4'd9;
    localparam logic [PC_W-1:0] S_EMIT     = 4'd10;
    localparam logic [PC_W-1:0] S_RETURN   = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic stop;      // current term ends the series
        logic div_last;  // divider is on its final digit step
    } t_status;

    // The control program: a jump is taken when the condition holds, else the next step follows.
    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        unique case (pc)
            S_WAIT:     uw = '{OP_LOAD,     C_NO_REQ,   S_WAIT};
            S_SQUARE:   uw = '{OP_SQUARE,   C_NEVER,    S_WAIT};
            S_INIT:     uw = '{OP_INIT,     C_NEVER,    S_WAIT};
            S_ACCUM:    uw = '{OP_ACCUM,    C_NEVER,    S_WAIT};
            S_TEST:     uw = '{OP_TEST,     C_STOP,     S_EMIT};
            S_MUL_LO:   uw = '{OP_MUL_LO,   C_NEVER,    S_WAIT};
            S_MUL_HI:   uw = '{OP_MUL_HI,   C_NEVER,    S_WAIT};
            S_DIV_INIT: uw = '{OP_DIV_INIT, C_NEVER,    S_WAIT};
            S_DIV_STEP: uw = '{OP_DIV_STEP, C_DIV_MORE, S_DIV_STEP};
            S_DIV_DONE: uw = '{OP_DIV_DONE, C_ALWAYS,   S_ACCUM};
            S_EMIT:     uw = '{OP_EMIT,     C_OUT_BUSY, S_EMIT};
            S_RETURN:   uw = '{OP_NOP,      C_ALWAYS,   S_WAIT};
            default:    uw = '{OP_NOP,      C_ALWAYS,   S_WAIT};
        endcase
        return uw;
    endfunction

    // Divisor (2n+1)(2n+2) for term n.
    function automatic logic [D_W-1:0] f_divisor(input logic [NIDX_W-1:0] n);
        logic [NIDX_W:0]   a;
        logic [NIDX_W+1:0] b;
        a = {n, 1'b1};
        b = {1'b0, n, 1'b0} + 8'd2;
        return D_W'(a * b);
    endfunction

endpackage

/* rtl/ssq_seq.sv */
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module ssq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req,
    input  logic                        i_out_free,
    input  ssq_pkg::t_status            i_status,
    output logic [ssq_pkg::OP_W-1:0]    o_op
);

    logic [ssq_pkg::PC_W-1:0] r_pc;
    logic [ssq_pkg::PC_W-1:0] n_pc;
    ssq_pkg::t_uword          w_uw;
    logic                     w_take;

    assign w_uw = ssq_pkg::f_ucode(r_pc);
    assign o_op = w_uw.op;

    always_comb begin
        unique case (w_uw.cond)
            ssq_pkg::C_NEVER:    w_take = 1'b0;
            ssq_pkg::C_ALWAYS:   w_take = 1'b1;
            ssq_pkg::C_NO_REQ:   w_take = !i_req;
            ssq_pkg::C_STOP:     w_take = i_status.stop;
            ssq_pkg::C_DIV_MORE: w_take = !i_status.div_last;
            ssq_pkg::C_OUT_BUSY: w_take = !i_out_free;
            default:             w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ssq_pkg::S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/ssq_dp.sv */
// Datapath: angle magnitude, multiplier, digit divider and saturating accumulator.
module ssq_dp #(
    parameter int MAX_TERMS = ssq_pkg::MAX_TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic [ssq_pkg::OP_W-1:0]          i_op,
    input  logic signed [ssq_pkg::ANGLE_W-1:0] i_angle,
    input  logic [ssq_pkg::TOL_W-1:0]         i_tolerance,
    output ssq_pkg::t_status                  o_status,
    output logic signed [ssq_pkg::SUM_W-1:0]  o_sum,
    output logic [$clog2(MAX_TERMS+1)-1:0]    o_count,
    output logic                              o_hit
);

    localparam int N_W   = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [ssq_pkg::AX_W-1:0]   r_ax;
    logic [ssq_pkg::ACC_W-1:0]  r_acc;
    logic [ssq_pkg::MAG_W-1:0]  r_mag;
    logic [ssq_pkg::Q4_W-1:0]   r_q4;
    logic [N_W-1:0]             r_n;
    logic [CNT_W-1:0]           r_count;
    logic                       r_hit;
    logic signed [ssq_pkg::SUM_W-1:0] r_sum;
    logic [ssq_pkg::D_W-1:0]    r_d;
    logic [ssq_pkg::DVD_W-1:0]  r_dvd;
    logic [ssq_pkg::D_W-1:0]    r_rem;
    logic [ssq_pkg::K_W-1:0]    r_k;

    logic [2*ssq_pkg::AX_W-2:0] w_sq_rnd;
    logic [ssq_pkg::X2_W-1:0]   w_x2;
    logic                       w_tol_met;
    logic [N_W-1:0]             w_n_inc;
    logic signed [ssq_pkg::SUM_W+1:0] w_sum_ext;
    logic [ssq_pkg::D_W-1:0]    w_rem_c;
    logic [ssq_pkg::D_W:0]      w_trial;
    logic [ssq_pkg::DIV_DIGIT-1:0] w_qbits;

    // Round x squared from Q5.56 to Q5.32, half up.
    assign w_sq_rnd  = r_acc[2*ssq_pkg::AX_W-2:0] + 61'h80_0000;
    assign w_x2      = w_sq_rnd[60:24];
    assign w_tol_met = r_mag <= {8'd0, i_tolerance};
    assign w_n_inc   = r_n + 1'b1;

    assign o_status.stop     = w_tol_met || (r_n == N_W'(MAX_TERMS - 1));
    assign o_status.div_last = r_k == ssq_pkg::K_W'(ssq_pkg::DIV_STEPS - 1);
    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_hit   = r_hit;

    // Term n has sign (-1)^n; the sum is widened by two bits before clamping.
    always_comb begin
        if (r_n[0]) begin
            w_sum_ext = {{2{r_sum[ssq_pkg::SUM_W-1]}}, r_sum} - $signed({2'b00, r_mag});
        end else begin
            w_sum_ext = {{2{r_sum[ssq_pkg::SUM_W-1]}}, r_sum} + $signed({2'b00, r_mag});
        end
    end

    // Eight restoring division steps per cycle on a 14-bit remainder.
    always_comb begin
        w_rem_c = r_rem;
        w_qbits = '0;
        w_trial = '0;
        for (int i = 0; i < ssq_pkg::DIV_DIGIT; i++) begin
            w_trial = {w_rem_c, r_dvd[ssq_pkg::DVD_W-1-i]};
            if (w_trial >= {1'b0, r_d}) begin
                w_rem_c = ssq_pkg::D_W'(w_trial - {1'b0, r_d});
                w_qbits[ssq_pkg::DIV_DIGIT-1-i] = 1'b1;
            end else begin
                w_rem_c = w_trial[ssq_pkg::D_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            ssq_pkg::OP_LOAD: begin
                if (i_angle[ssq_pkg::ANGLE_W-1]) begin
                    r_ax <= ssq_pkg::AX_W'(32'h8000_0000 - {1'b0, i_angle});
                end else begin
                    r_ax <= i_angle;
                end
            end
            ssq_pkg::OP_SQUARE: begin
                r_acc <= ssq_pkg::ACC_W'(r_ax * r_ax);
            end
            ssq_pkg::OP_INIT: begin
                r_mag   <= {3'b000, w_x2};
                r_q4    <= {w_x2, 2'b00};
                r_n     <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end
            ssq_pkg::OP_ACCUM: begin
                if (w_sum_ext[41:39] == 3'b000 || w_sum_ext[41:39] == 3'b111) begin
                    r_sum <= w_sum_ext[ssq_pkg::SUM_W-1:0];
                end else if (w_sum_ext[41]) begin
                    r_sum <= {1'b1, 39'd0};
                end else begin
                    r_sum <= {1'b0, {39{1'b1}}};
                end
                r_count <= r_count + 1'b1;
            end
            ssq_pkg::OP_TEST: begin
                r_hit <= !w_tol_met;
                r_n   <= w_n_inc;
                r_d   <= ssq_pkg::f_divisor(ssq_pkg::NIDX_W'(w_n_inc));
            end
            ssq_pkg::OP_MUL_LO: begin
                r_acc <= ssq_pkg::ACC_W'(r_mag * r_q4[ssq_pkg::MLO_W-1:0]);
            end
            ssq_pkg::OP_MUL_HI: begin
                r_acc <= r_acc
                         + {(ssq_pkg::ACC_W-ssq_pkg::MLO_W)'(
                                r_mag * r_q4[ssq_pkg::Q4_W-1:ssq_pkg::MLO_W]),
                            {ssq_pkg::MLO_W{1'b0}}};
            end
            ssq_pkg::OP_DIV_INIT: begin
                r_dvd <= {1'b0, r_acc[ssq_pkg::ACC_W-1:32]}
                         + {35'd0, r_d[ssq_pkg::D_W-1:1]};
                r_rem <= '0;
                r_k   <= '0;
            end
            ssq_pkg::OP_DIV_STEP: begin
                r_dvd <= {r_dvd[ssq_pkg::DVD_W-ssq_pkg::DIV_DIGIT-1:0], w_qbits};
                r_rem <= w_rem_c;
                r_k   <= r_k + 1'b1;
            end
            ssq_pkg::OP_DIV_DONE: begin
                if (r_dvd[ssq_pkg::DVD_W-1:ssq_pkg::MAG_W] != '0) begin
                    r_mag <= '1;
                end else begin
                    r_mag <= r_dvd[ssq_pkg::MAG_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/sine_squared_series_approx.sv */
// Top level of the sine-squared Taylor series block: sequencer, datapath and output register.
// Each term past the first runs through the two multiplier passes and the six eight-bit
// steps of the divider. Once the result is loaded, the sequencer passes through its return
// step back to the wait step, where a new request can be taken.
// Reset (i_rst_n low at a clock edge) returns the sequencer to its wait step, empties the
// output register and sets the tolerance to 4295.
module sine_squared_series_approx #(
    parameter int MAX_TERMS = ssq_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [ssq_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ssq_pkg::SUM_W-1:0]   o_approximation,
    output logic [ssq_pkg::CNT_OUT_W-1:0]      o_term_count,
    output logic                               o_limit_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssq_pkg::TOL_W-1:0]          i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [ssq_pkg::OP_W-1:0]         w_op;
    ssq_pkg::t_status                 w_status;
    logic signed [ssq_pkg::SUM_W-1:0] w_sum;
    logic [CNT_W-1:0]                 w_count;
    logic                             w_hit;
    logic                             w_out_free;
    logic                             w_emit;

    logic [ssq_pkg::TOL_W-1:0]        r_tolerance;
    logic                             r_out_valid;
    logic signed [ssq_pkg::SUM_W-1:0] r_out_sum;
    logic [ssq_pkg::CNT_OUT_W-1:0]    r_out_count;
    logic                             r_out_hit;

    // The sequencer waits in its first step with the input side open. A request
    // accepted there starts the program, which runs the series term by term and
    // finishes by loading the output register.
    assign o_in_ready = (w_op == ssq_pkg::OP_LOAD);

    // The output register frees up in the same cycle its result is taken, so the
    // emit step never waits longer than the consumer does.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (w_op == ssq_pkg::OP_EMIT) && w_out_free;

    // The tolerance register takes a write in every cycle. Writes must be made only while no
    // request is in flight, so a running series sees a fixed threshold; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    ssq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_in_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_op       (w_op)
    );

    ssq_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_angle     (i_angle),
        .i_tolerance (r_tolerance),
        .o_status    (w_status),
        .o_sum       (w_sum),
        .o_count     (w_count),
        .o_hit       (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= ssq_pkg::TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tolerance <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload: the term count wraps to the six bits of the port.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sum   <= w_sum;
            r_out_count <= ssq_pkg::CNT_OUT_W'(w_count);
            r_out_hit   <= w_hit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_approximation = r_out_sum;
    assign o_term_count    = r_out_count;
    assign o_limit_hit     = r_out_hit;

    // An accepted request always moves the program on to squaring the angle.
    a_start_square : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (w_op == ssq_pkg::OP_SQUARE))
        else $error("request accepted but squaring step did not follow");

    // A result appears only out of the emit step.
    a_emit_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_op == ssq_pkg::OP_EMIT))
        else $error("output became valid outside the emit step");

    // The cap flag implies the full number of terms was added.
    a_cap_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_limit_hit) |->
        (o_term_count == ssq_pkg::CNT_OUT_W'(MAX_TERMS)))
        else $error("limit flag set with a short term count");

    // No new request is taken while a series is being worked on.
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input side reopened during a series");

endmodule

/* bench/sine_squared_series_approx_test.sv */
// Self-checking testbench for the sine-squared series block: directed table, then random angles.
module sine_squared_series_approx_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Angle limits in Q3.28: pi, pi/2 and one (2^28).
    localparam int PI_Q28      = 843314857;
    localparam int HALF_PI_Q28 = 421657428;
    localparam int ONE_Q28     = 268435456;

    // One result of the block, field by field at port widths.
    typedef struct packed {
        logic signed [ssq_pkg::SUM_W-1:0] approximation;
        logic [ssq_pkg::CNT_OUT_W-1:0]    term_count;
        logic                             limit_hit;
    } t_series_result;

    // One row of the directed table. When known is set, the row carries its own
    // expected result; otherwise the predictor supplies it.
    typedef struct packed {
        logic [ssq_pkg::TOL_W-1:0]          tolerance;
        logic signed [ssq_pkg::ANGLE_W-1:0] angle;
        logic                               known;
        t_series_result                     result;
    } t_angle_case;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 50;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic signed [ssq_pkg::ANGLE_W-1:0]  i_angle = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [ssq_pkg::SUM_W-1:0]    o_approximation;
    logic [ssq_pkg::CNT_OUT_W-1:0]       o_term_count;
    logic                                o_limit_hit;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [ssq_pkg::TOL_W-1:0]           i_cfg_data = '0;

    // Tolerance as the block should currently hold it; it follows every accepted write.
    logic [ssq_pkg::TOL_W-1:0]           tolerance_now = ssq_pkg::TOL_RESET;

    // Results still owed by the block, oldest first.
    t_series_result               owed_results[$];

    int error_count    = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int tol_writes     = 0;
    int burst_left     = 0;
    int ready_left     = 0;
    logic [31:0]                  ready_pattern = '1;

    // The directed table. Rows whose answer is obvious by hand carry it: a zero or
    // tiny angle squares to zero and stops on the first term, and an angle of 2^12
    // squares to exactly one LSB of Q8.32, which is below the reset tolerance.
    t_angle_case directed_cases [NUM_DIRECTED] = '{
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(0),    1'b1, '{40'sd0, 6'd1, 1'b0}},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(1),    1'b1, '{40'sd0, 6'd1, 1'b0}},
        '{ssq_pkg::TOL_RESET, -31'sd1,                 1'b1, '{40'sd0, 6'd1, 1'b0}},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(4096), 1'b1, '{40'sd1, 6'd1, 1'b0}},
        // Just below and just above the rounding point of the square.
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(2896),        1'b0, '0},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(2897),        1'b0, '0},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(PI_Q28),      1'b0, '0},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(-PI_Q28),     1'b0, '0},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(HALF_PI_Q28), 1'b0, '0},
        '{ssq_pkg::TOL_RESET, ssq_pkg::ANGLE_W'(ONE_Q28),     1'b0, '0},
        // Beyond pi: largest positive and most negative codes; then two alternating-bit codes.
        '{ssq_pkg::TOL_RESET, 31'sh3FFF_FFFF,                 1'b0, '0},
        '{ssq_pkg::TOL_RESET, 31'sh4000_0000,                 1'b0, '0},
        '{ssq_pkg::TOL_RESET, 31'sh2AAA_AAAA,                 1'b0, '0},
        '{ssq_pkg::TOL_RESET, 31'sh5555_5555,                 1'b0, '0},
        // Zero tolerance: only a zero term ends the series early.
        '{32'd0,     ssq_pkg::ANGLE_W'(0),           1'b1, '{40'sd0, 6'd1, 1'b0}},
        '{32'd0,     ssq_pkg::ANGLE_W'(PI_Q28),      1'b0, '0},
        '{32'd0,     31'sh3FFF_FFFF,                 1'b0, '0},
        '{32'd0,     ssq_pkg::ANGLE_W'(4096),        1'b0, '0},
        // Largest tolerance: most series end after the first term.
        '{32'hFFFF_FFFF, ssq_pkg::ANGLE_W'(0),       1'b1, '{40'sd0, 6'd1, 1'b0}},
        '{32'hFFFF_FFFF, ssq_pkg::ANGLE_W'(ONE_Q28), 1'b0, '0},
        '{32'hFFFF_FFFF, ssq_pkg::ANGLE_W'(-PI_Q28), 1'b0, '0},
        // Smallest nonzero tolerance.
        '{32'd1,     ssq_pkg::ANGLE_W'(PI_Q28),      1'b0, '0},
        '{32'd1,     ssq_pkg::ANGLE_W'(1),           1'b1, '{40'sd0, 6'd1, 1'b0}}
    };

    sine_squared_series_approx u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_angle         (i_angle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_approximation (o_approximation),
        .o_term_count    (o_term_count),
        .o_limit_hit     (o_limit_hit),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Series sum for one angle. The square of |x| is rounded to Q8.32, then each
    // new term magnitude is the previous one times 4x^2 (scaled back by 2^32, floored)
    // divided by (2n+1)(2n+2) with round half up. Signs alternate, the sum saturates
    // to Q8.32 after every term, and the series stops on the first term whose
    // magnitude does not exceed the tolerance, or at the term cap.
    function automatic t_series_result predict_sine_squared(
        input logic signed [ssq_pkg::ANGLE_W-1:0] angle,
        input logic [ssq_pkg::TOL_W-1:0]          tol
    );
        logic [ssq_pkg::ANGLE_W-1:0] raw;
        logic [63:0]        ax;
        logic [63:0]        x2;
        logic [63:0]        q4;
        logic [63:0]        mag;
        logic [63:0]        divisor;
        logic [127:0]       prod;
        logic signed [63:0] sum;
        int unsigned        terms;
        logic               capped;
        t_series_result     res;
        raw = angle;
        ax = raw[ssq_pkg::ANGLE_W-1] ? (64'h8000_0000 - 64'(raw)) : 64'(raw);
        x2 = (ax * ax + 64'h80_0000) >> 24;
        q4 = x2 << 2;
        mag = x2;
        sum = '0;
        terms = 0;
        capped = 1'b1;
        for (int unsigned n = 0; n < ssq_pkg::MAX_TERMS_DEF; n++) begin
            if (n > 0) begin
                divisor = 64'((2 * n + 1) * (2 * n + 2));
                prod = {64'd0, mag} * {64'd0, q4};
                mag = (prod[95:32] + divisor / 2) / divisor;
                if (mag > 64'hFF_FFFF_FFFF) begin
                    mag = 64'hFF_FFFF_FFFF;
                end
            end
            if (n[0]) begin
                sum = sum - $signed(mag);
            end else begin
                sum = sum + $signed(mag);
            end
            if (sum > 64'sh7F_FFFF_FFFF) begin
                sum = 64'sh7F_FFFF_FFFF;
            end
            if (sum < -64'sh80_0000_0000) begin
                sum = -64'sh80_0000_0000;
            end
            terms++;
            if (mag <= 64'(tol)) begin
                capped = 1'b0;
                break;
            end
        end
        res.approximation = sum[ssq_pkg::SUM_W-1:0];
        res.term_count    = ssq_pkg::CNT_OUT_W'(terms);
        res.limit_hit     = capped;
        return res;
    endfunction

    // Random angle: mostly inside plus or minus pi, a good share over the whole code
    // range, some very small values and some near the edges.
    function automatic logic signed [ssq_pkg::ANGLE_W-1:0] random_angle();
        int unsigned                        pick;
        logic signed [ssq_pkg::ANGLE_W-1:0] a;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            a = ssq_pkg::ANGLE_W'(int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28);
        end else if (pick < 7) begin
            a = ssq_pkg::ANGLE_W'($urandom);
        end else if (pick < 9) begin
            a = ssq_pkg::ANGLE_W'($urandom >> $urandom_range(8, 30));
            if ($urandom_range(0, 1) == 1) begin
                a = -a;
            end
        end else begin
            a = ($urandom_range(0, 1) == 1) ? ssq_pkg::ANGLE_W'(PI_Q28) : 31'sh3FFF_FFFF;
            a = a - ssq_pkg::ANGLE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
                a = -a;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Writes the tolerance once the block has delivered every owed result. Every
    // request here yields exactly one result, so an empty queue means the block is idle.
    task automatic write_tolerance(input logic [ssq_pkg::TOL_W-1:0] value);
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        tolerance_now = value;
        tol_writes++;
    endtask

    // Presents one angle request and holds it until accepted. The expected result is
    // queued at the accepting edge. The sender runs in bursts; at the end of a burst
    // valid drops for a random gap.
    task automatic send_angle(
        input logic signed [ssq_pkg::ANGLE_W-1:0] angle,
        input logic                               known,
        input t_series_result                     known_result
    );
        i_in_valid <= 1'b1;
        i_angle    <= angle;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        owed_results.push_back(known ? known_result
                                     : predict_sine_squared(angle, tolerance_now));
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Receiver stalls: each time the 32-bit ready pattern is used up a new one is picked, from always
    // ready to mostly stalled, so back-pressure lands on results of every length.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_left = 32;
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;
                1:       ready_pattern = $urandom;
                2:       ready_pattern = $urandom | $urandom;
                default: ready_pattern = ($urandom & $urandom) | 32'h8000_0001;
            endcase
        end
        i_out_ready   <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        ready_left--;
    end

    // Result checker: every accepted result is compared against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_series_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%h with no request outstanding",
                                          o_approximation));
            end else begin
                want = owed_results.pop_front();
                if (o_approximation !== want.approximation) begin
                    report_mismatch($sformatf("approximation got 0x%h want 0x%h",
                                              o_approximation, want.approximation));
                end
                if (o_term_count !== want.term_count) begin
                    report_mismatch($sformatf("term_count got %0d want %0d",
                                              o_term_count, want.term_count));
                end
                if (o_limit_hit !== want.limit_hit) begin
                    report_mismatch($sformatf("limit_hit got %b want %b",
                                              o_limit_hit, want.limit_hit));
                end
                results_seen++;
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases at several tolerances.
    initial begin
        logic [ssq_pkg::TOL_W-1:0] phase_tol [NUM_PHASES];
        phase_tol[0] = ssq_pkg::TOL_RESET;
        phase_tol[1] = 32'hFFFF_FFFF;
        phase_tol[2] = 32'd1;
        phase_tol[3] = 32'd0;
        phase_tol[4] = $urandom;
        phase_tol[5] = $urandom_range(1, 1 << 16);
        phase_tol[6] = $urandom >> $urandom_range(0, 31);
        phase_tol[7] = ssq_pkg::TOL_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first rows run on the tolerance left by reset; later rows change it
        // only between requests, after the block has drained.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_cases[i].tolerance != tolerance_now) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                write_tolerance(directed_cases[i].tolerance);
            end
            send_angle(directed_cases[i].angle, directed_cases[i].known,
                       directed_cases[i].result);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_tolerance(phase_tol[p]);
            repeat (PHASE_ITEMS) send_angle(random_angle(), 1'b0, '0);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end

        // Drain, then give the block a full worst-case series time to show any
        // stray result.
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (400) @(posedge i_clk);

        $display("Sent %0d angle requests over %0d tolerance writes; %0d results checked.",
                 requests_sent, tol_writes, results_seen);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0) begin
            $display("sine_squared_series_approx test passed");
        end else begin
            $display("sine_squared_series_approx test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (every series at the term cap,
    // the receiver's longest stalls and the sender's longest gaps).
    initial begin
        #20_000_000;
        $display("Timeout with %0d results still owed.", owed_results.size());
        $display("sine_squared_series_approx test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/ssq_pkg.sv
rtl/ssq_seq.sv
rtl/ssq_dp.sv
rtl/sine_squared_series_approx.sv
bench/sine_squared_series_approx_test.sv
